>>> design/cttk_pkg.sv
// Package for the configuration text tokenizer: item types, byte codes,
// result kinds, scan states and queue sizing. No dependencies.
`default_nettype none

package cttk_pkg;

    // Largest token or string buffer; a token is cut at BUFFER_SIZE-1 bytes.
    localparam int BUFFER_SIZE = 2048;
    localparam int CNT_W       = $clog2(BUFFER_SIZE);
    localparam int LEN_W       = 11;
    localparam int LINE_W      = 24;

    // Queue between the scanner and the output stage, in result pairs.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Byte codes
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Result kinds
    localparam logic [2:0] KIND_TOKEN_BYTE = 3'd0;
    localparam logic [2:0] KIND_DATA_BYTE  = 3'd1;
    localparam logic [2:0] KIND_TOKEN_END  = 3'd2;
    localparam logic [2:0] KIND_DATA_END   = 3'd3;
    localparam logic [2:0] KIND_STREAM_END = 3'd4;

    // Register map (byte addresses on the APB port)
    localparam int          PADDR_W         = 3;
    localparam logic [2:0]  REG_ESCAPE_ADDR = 3'd0;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_COMMENT   = 3'd1,
        ST_TOKEN     = 3'd2,
        ST_TOKEN_ESC = 3'd3,
        ST_QUOTE     = 3'd4,
        ST_QUOTE_ESC = 3'd5
    } cttk_scan_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_stream;
    } cttk_in_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        char_value;
        logic [LEN_W-1:0]  token_length;
        logic [LINE_W-1:0] line_number;
        logic              too_long;
        logic              missing_quote;
        logic              last;
    } cttk_out_t;

    // All results of one input item: one or two.
    typedef struct packed {
        cttk_out_t r0;
        cttk_out_t r1;
        logic      two;
    } cttk_pair_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cttk_qstat_t;

    // Token count to the fixed output length field, modulo 2048.
    function automatic logic [LEN_W-1:0] cttk_len(input logic [CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[LEN_W-1:0];
    endfunction

endpackage : cttk_pkg

`default_nettype wire

>>> design/config_text_tokenizer_top.sv
// Top level of the configuration text tokenizer: APB register, scanner,
// result queue and output stage. Uses cttk_pkg, cttk_front, cttk_queue, cttk_back.
//
// Usage:
//  - Input channel (byte_valid/byte_stall/byte_item): one text byte per item,
//    or an end-of-stream marker. An item is taken at a rising edge with
//    byte_valid high and byte_stall low.
//  - Output channel (tok_valid/tok_stall/tok_item): token bytes, data bytes,
//    end markers and the end-of-stream marker, one result per item; last
//    marks the final result caused by an input item.
//  - APB port: register 0 (address 0) holds escape_mode in bit 0. Write it
//    only while the block is idle.
// Timing:
//  - One input item per cycle is accepted while the queue is not full; the
//    scanner updates its state in the same cycle, so bytes can follow back to back.
//  - Each result passes through the pair queue and then the output stage's
//    holding register before tok_valid rises for it.
//  - An input item makes zero, one or two results. The output stage sends
//    one result per cycle while tok_stall is low, so a long run of two-result
//    items is limited by that stage; the four-entry pair queue absorbs such
//    bursts, and byte_stall rises only when the queue is full.
// Reset: rst_n clears scan state, counters, queue and escape_mode. When the
// receiver stalls, the current result holds on tok_item and the queue fills.
`default_nettype none

module config_text_tokenizer_top
    import cttk_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    // APB configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,

    // byte input channel
    input  wire logic                byte_valid,
    output logic                     byte_stall,
    input  wire cttk_in_t            byte_item,

    // token result channel
    output logic                     tok_valid,
    input  wire logic                tok_stall,
    output cttk_out_t                tok_item
);

    logic         escape_reg;
    logic         take;
    logic         push;
    logic         pop;
    cttk_pair_t   pair;
    cttk_pair_t   qdata;
    cttk_qstat_t  qstat;

    // APB register: always ready, single bit at address 0
    assign pready = 1'b1;
    assign prdata = (paddr == REG_ESCAPE_ADDR) ? {31'd0, escape_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            escape_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr == REG_ESCAPE_ADDR)
            escape_reg <= pwdata[0];
    end

    // Input is held back only while the pair queue is full
    assign byte_stall = qstat.full;
    assign take       = byte_valid && !qstat.full;

    cttk_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .item        (byte_item),
        .escape_mode (escape_reg),
        .push        (push),
        .pair        (pair)
    );

    cttk_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (pair),
        .pop   (pop),
        .rdata (qdata),
        .stat  (qstat)
    );

    cttk_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .qdata (qdata),
        .qstat (qstat),
        .pop   (pop),
        .valid (tok_valid),
        .stall (tok_stall),
        .item  (tok_item)
    );

endmodule : config_text_tokenizer_top

`default_nettype wire

>>> design/cttk_front.sv
// Scanner front end: classifies each accepted byte, keeps scan state,
// token count and line count, and builds the item's result pair. Uses cttk_pkg.
`default_nettype none

module cttk_front
    import cttk_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire cttk_in_t   item,
    input  wire logic       escape_mode,
    output logic            push,
    output cttk_pair_t      pair
);

    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(BUFFER_SIZE - 1);

    cttk_scan_t          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [LINE_W-1:0]   line_reg, line_next;

    logic [7:0]          b;
    logic                is_bs;
    logic                is_sep;
    logic                do_add;
    logic                add_data;
    logic [CNT_W-1:0]    cnt_inc;
    logic                limit_hit;
    logic [1:0]          nres;
    cttk_out_t           r0, r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            line_reg  <= '0;
        end
        else if (take)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            line_reg  <= line_next;
        end
    end

    always_comb
    begin
        b         = item.byte_in;
        is_bs     = escape_mode && (b == CH_BSLASH);
        is_sep    = (b <= CH_SPACE) || (b == CH_COMMA);
        cnt_inc   = count_reg + 1'b1;
        limit_hit = (cnt_inc == LIMIT);

        state_next = state_reg;
        count_next = count_reg;
        line_next  = line_reg;
        do_add     = 1'b0;
        add_data   = 1'b0;
        nres       = 2'd0;
        r0         = '0;
        r1         = '0;

        if (item.end_of_stream)
        begin
            r0.line_number = line_reg;
            r1.line_number = line_reg;
            if (state_reg == ST_TOKEN || state_reg == ST_TOKEN_ESC)
            begin
                r0.kind         = KIND_TOKEN_END;
                r0.token_length = cttk_len(count_reg);
                r1.kind         = KIND_STREAM_END;
                nres            = 2'd2;
            end
            else if (state_reg == ST_QUOTE || state_reg == ST_QUOTE_ESC)
            begin
                r0.kind          = KIND_DATA_END;
                r0.token_length  = cttk_len(count_reg);
                r0.missing_quote = 1'b1;
                r1.kind          = KIND_STREAM_END;
                nres             = 2'd2;
            end
            else
            begin
                r0.kind = KIND_STREAM_END;
                nres    = 2'd1;
            end
            state_next = ST_IDLE;
            count_next = '0;
            line_next  = '0;
        end
        else
        begin
            if (b == CH_LF && line_reg != {LINE_W{1'b1}})
                line_next = line_reg + 1'b1;
            r0.line_number = line_next;
            r1.line_number = line_next;

            case (state_reg)
                ST_COMMENT:
                begin
                    if (b == CH_LF)
                        state_next = ST_IDLE;
                end
                ST_TOKEN:
                begin
                    if (is_bs)
                        state_next = ST_TOKEN_ESC;
                    else if (is_sep)
                    begin
                        r0.kind         = KIND_TOKEN_END;
                        r0.token_length = cttk_len(count_reg);
                        nres            = 2'd1;
                        state_next      = ST_IDLE;
                        count_next      = '0;
                    end
                    else
                        do_add = 1'b1;
                end
                ST_TOKEN_ESC:
                    do_add = 1'b1;
                ST_QUOTE:
                begin
                    if (b == CH_CR)
                        state_next = ST_QUOTE;
                    else if (is_bs)
                        state_next = ST_QUOTE_ESC;
                    else if (b == CH_QUOTE || b == CH_LF)
                    begin
                        r0.kind          = KIND_DATA_END;
                        r0.token_length  = cttk_len(count_reg);
                        r0.missing_quote = (b == CH_LF);
                        nres             = 2'd1;
                        state_next       = ST_IDLE;
                        count_next       = '0;
                    end
                    else
                    begin
                        do_add   = 1'b1;
                        add_data = 1'b1;
                    end
                end
                ST_QUOTE_ESC:
                begin
                    do_add   = 1'b1;
                    add_data = 1'b1;
                end
                default:
                begin
                    // between tokens; also covers unused codes
                    state_next = ST_IDLE;
                    count_next = '0;
                    cnt_inc    = CNT_W'(1);
                    limit_hit  = (cnt_inc == LIMIT);
                    if (is_bs)
                        state_next = ST_TOKEN_ESC;
                    else if (b == CH_HASH)
                        state_next = ST_COMMENT;
                    else if (b == CH_QUOTE)
                        state_next = ST_QUOTE;
                    else if (!is_sep)
                        do_add = 1'b1;
                end
            endcase

            if (do_add)
            begin
                r0.kind       = add_data ? KIND_DATA_BYTE : KIND_TOKEN_BYTE;
                r0.char_value = b;
                nres          = 2'd1;
                if (limit_hit)
                begin
                    r1.kind         = add_data ? KIND_DATA_END : KIND_TOKEN_END;
                    r1.token_length = cttk_len(cnt_inc);
                    r1.too_long     = 1'b1;
                    nres            = 2'd2;
                    state_next      = ST_IDLE;
                    count_next      = '0;
                end
                else
                begin
                    state_next = add_data ? ST_QUOTE : ST_TOKEN;
                    count_next = cnt_inc;
                end
            end
        end

        r0.last  = (nres != 2'd2);
        r1.last  = 1'b1;
        pair.r0  = r0;
        pair.r1  = r1;
        pair.two = (nres == 2'd2);
        push     = take && (nres != 2'd0);
    end

    a_count_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < LIMIT)
        else $error("token count reached the cut limit without being cleared");

    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_COMMENT) |-> count_reg == '0)
        else $error("token count not cleared outside a token");

endmodule : cttk_front

`default_nettype wire

>>> design/cttk_queue.sv
// Short queue of result pairs between scanner and output stage.
// Register array with read and write pointers. Uses cttk_pkg.
`default_nettype none

module cttk_queue
    import cttk_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire cttk_pair_t  wdata,
    input  wire logic        pop,
    output cttk_pair_t       rdata,
    output cttk_qstat_t      stat
);

    cttk_pair_t           mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wptr_reg, rptr_reg;
    logic [QCNT_W-1:0]    cnt_reg;
    logic                 do_push, do_pop;

    assign stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rdata      = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("result pair pushed into a full queue");

endmodule : cttk_queue

`default_nettype wire

>>> design/cttk_back.sv
// Output stage: takes result pairs from the queue and hands them out one
// item per cycle while stall is low, from a holding register. Uses cttk_pkg.
`default_nettype none

module cttk_back
    import cttk_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cttk_pair_t   qdata,
    input  wire cttk_qstat_t  qstat,
    output logic              pop,
    output logic              valid,
    input  wire logic         stall,
    output cttk_out_t         item
);

    cttk_pair_t  ent_reg;
    logic        have_reg;
    logic        sel_reg;
    logic        sent;
    logic        step_second;
    logic        need_next;

    assign sent        = have_reg && !stall;
    assign step_second = sent && !sel_reg && ent_reg.two;
    assign need_next   = (!have_reg || sent) && !step_second;
    assign pop         = need_next && !qstat.empty;
    assign valid       = have_reg;
    assign item        = sel_reg ? ent_reg.r1 : ent_reg.r0;

    always_ff @(posedge clk)
    begin
        if (pop)
            ent_reg <= qdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
            sel_reg  <= 1'b0;
        end
        else if (step_second)
        begin
            sel_reg <= 1'b1;
        end
        else if (need_next)
        begin
            have_reg <= !qstat.empty;
            sel_reg  <= 1'b0;
        end
    end

    a_second_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> (have_reg && ent_reg.two))
        else $error("second result selected without a pair loaded");

endmodule : cttk_back

`default_nettype wire
